// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers; they expand to nothing when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define FLA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be true at a clock edge outside reset.
`define FLA_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define FLA_ASSERT(label, clk, rst_n, prop, msg)
`define FLA_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// ===== rtl/core/fla32_pkg.sv =====
// ---------------------------------------------------------------------------
// fla32_pkg
// Shared constants, codes and types of the frame length / Adler-32 framer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fla32_pkg;

	localparam int BUFFER_BYTES = 16384;
	localparam int TAIL_SLACK   = 32;
	localparam int HEAD_ROOM    = 4;
	localparam int TRAILER_LEN  = 4;

	// Capacity compare is done at 18 bits: count (16) plus small offsets.
	localparam logic [17:0] FIT_LIMIT = 18'(BUFFER_BYTES - TAIL_SLACK);
	localparam logic [16:0] ADLER_MOD = 17'd65521;

	typedef enum logic {
		OP_BODY   = 1'b0,
		OP_FINISH = 1'b1
	} fla_op_t;

	typedef enum logic {
		REG_WRITES_ALLOWED  = 1'b0,
		REG_CHECKSUM_ENABLE = 1'b1
	} fla_reg_t;

	// Request from the input stage to the accumulator.
	typedef struct packed {
		logic       byte_en;
		logic       finish;
		logic [7:0] data;
		logic       writes_allowed;
	} fla_acc_req_t;

	// Running message state seen by the result logic.
	typedef struct packed {
		logic [15:0] sum_low;
		logic [15:0] sum_high;
		logic [15:0] byte_count;
		logic        drop_seen;
		logic        room4;
	} fla_acc_stat_t;

endpackage

// ===== rtl/core/frame_length_adler32_header.sv =====
// ---------------------------------------------------------------------------
// frame_length_adler32_header
// Outgoing message framer: counts body bytes, runs Adler-32, emits header.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream carries one request per beat: tuser = op (0 body byte,
//   1 finish), tdata = the body byte. A body byte yields no result; it is
//   counted and folded into the Adler-32 when writes are allowed and the
//   buffer still has room, else it is dropped and the drop flag is set.
//   A finish yields one result on the master stream: tdata holds the
//   length word and the checksum, tuser the present and dropped flags.
//   A request is registered in the input register and processed from
//   there; a finish result is then loaded into the output register.
//   Throughput: one request per cycle while no finish waits, set by the
//   single add-and-reduce pass through the two accumulators.
//   Stall: while the receiver holds off, a finish waits in the input
//   register behind the untaken result and the slave stream stops
//   accepting; body bytes advance only while no finish is waiting.
//   Reset: writes_allowed and checksum_enable come up as 1, a = 1, b = 0,
//   count 0, no drop seen, both streams empty.
//   Configuration: cfg_we with cfg_index / cfg_data, written while idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module frame_length_adler32_header (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic        cfg_data,
	// Slave stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] op
	// Master stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // [15:0] length_field, [47:16] checksum
	output logic [1:0]  m_axis_tuser    // [0] checksum_present, [1] bytes_dropped
);
	import fla32_pkg::*;

	// Configuration registers
	logic writes_allowed_q;
	logic checksum_enable_q;

	// Input register
	logic       s1_valid_q;
	fla_op_t    op_s1;
	logic [7:0] byte_s1;

	// Output register
	logic        m_valid_q;
	logic [47:0] m_tdata_q;
	logic [1:0]  m_tuser_q;

	logic          s1_go;
	logic          s_accept;
	logic          finish_go;
	fla_acc_req_t  acc_req;
	fla_acc_stat_t acc_stat;
	logic          present;
	logic [15:0]   length_word;
	logic [31:0]   sum_word;

	// Configuration: only bit 0 of the data is kept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			writes_allowed_q  <= 1'b1;
			checksum_enable_q <= 1'b1;
		end else if (cfg_we) begin
			case (fla_reg_t'(cfg_index))
				REG_WRITES_ALLOWED:  writes_allowed_q  <= cfg_data;
				REG_CHECKSUM_ENABLE: checksum_enable_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A body byte always advances; a finish advances only when the output
	// register is free or is being emptied this cycle.
	assign s1_go = s1_valid_q && ((op_s1 == OP_BODY) || !m_valid_q || m_axis_tready);
	assign finish_go = s1_go && (op_s1 == OP_FINISH);
	assign s_axis_tready = !s1_valid_q || s1_go;
	assign s_accept = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_go) begin
			s1_valid_q <= 1'b0;
		end
	end

	// Payload of the input register needs no reset.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			op_s1   <= fla_op_t'(s_axis_tuser);
			byte_s1 <= s_axis_tdata;
		end
	end

	assign acc_req = '{
		byte_en:        s1_go && (op_s1 == OP_BODY),
		finish:         finish_go,
		data:           byte_s1,
		writes_allowed: writes_allowed_q
	};

	fla32_acc u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (acc_req),
		.stat   (acc_stat)
	);

	// Trailer goes in only when enabled, writes are allowed and four more bytes still fit.
	always_comb begin
		present     = checksum_enable_q && acc_stat.room4;
		length_word = acc_stat.byte_count + (present ? 16'(TRAILER_LEN) : 16'd0);
		sum_word    = present ? {acc_stat.sum_high, acc_stat.sum_low} : 32'd0;
	end

	// Output register: load on finish, drop valid once the result is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (finish_go) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish_go) begin
			m_tdata_q <= {sum_word, length_word};
			m_tuser_q <= {acc_stat.drop_seen, present};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tuser  = m_tuser_q;

	`FLA_ASSERT(a_finish_out, clk, arst_n, finish_go |=> m_valid_q, "finish did not load a result")
	`FLA_ASSERT_NEVER(a_no_overwrite, clk, arst_n, finish_go && m_valid_q && !m_axis_tready, "result overwritten while stalled")
	`FLA_ASSERT_NEVER(a_absent_zero, clk, arst_n, m_valid_q && !m_tuser_q[0] && (m_tdata_q[47:16] != 32'd0), "checksum nonzero without trailer")
	`FLA_ASSERT_NEVER(a_present_len, clk, arst_n, m_valid_q && m_tuser_q[0] && (m_tdata_q[15:0] < 16'(TRAILER_LEN)), "length missing trailer bytes")

endmodule

// ===== rtl/core/fla32_acc.sv =====
// ---------------------------------------------------------------------------
// fla32_acc
// Adler-32 accumulators, body byte count and drop flag of one message.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fla32_acc (
	input  logic                    clk,
	input  logic                    arst_n,
	input  fla32_pkg::fla_acc_req_t req,
	output fla32_pkg::fla_acc_stat_t stat
);
	import fla32_pkg::*;

	logic [15:0] sum_low_q;
	logic [15:0] sum_high_q;
	logic [15:0] byte_count_q;
	logic        drop_seen_q;

	logic        fits1;
	logic        room4;
	logic [16:0] a_sum;
	logic [16:0] a_red;
	logic [16:0] b_sum;
	logic [16:0] b_red;

	// Capacity: head room plus count plus request size stays below the limit.
	assign fits1 = req.writes_allowed &&
		(({2'b00, byte_count_q} + 18'(HEAD_ROOM + 1)) < FIT_LIMIT);
	assign room4 = req.writes_allowed &&
		(({2'b00, byte_count_q} + 18'(HEAD_ROOM + TRAILER_LEN)) < FIT_LIMIT);

	// Both sums stay below twice the modulus, so one subtract reduces them.
	always_comb begin
		a_sum = {1'b0, sum_low_q} + {9'd0, req.data};
		a_red = (a_sum >= ADLER_MOD) ? (a_sum - ADLER_MOD) : a_sum;
		b_sum = {1'b0, sum_high_q} + a_red;
		b_red = (b_sum >= ADLER_MOD) ? (b_sum - ADLER_MOD) : b_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_low_q    <= 16'd1;
			sum_high_q   <= 16'd0;
			byte_count_q <= 16'd0;
			drop_seen_q  <= 1'b0;
		end else if (req.finish) begin
			sum_low_q    <= 16'd1;
			sum_high_q   <= 16'd0;
			byte_count_q <= 16'd0;
			drop_seen_q  <= 1'b0;
		end else if (req.byte_en) begin
			if (fits1) begin
				sum_low_q    <= a_red[15:0];
				sum_high_q   <= b_red[15:0];
				byte_count_q <= byte_count_q + 16'd1;
			end else begin
				drop_seen_q <= 1'b1;
			end
		end
	end

	assign stat = '{
		sum_low:    sum_low_q,
		sum_high:   sum_high_q,
		byte_count: byte_count_q,
		drop_seen:  drop_seen_q,
		room4:      room4
	};

	`FLA_ASSERT(a_reduced_a, clk, arst_n, ({1'b0, sum_low_q} < ADLER_MOD), "sum_low not reduced")
	`FLA_ASSERT(a_reduced_b, clk, arst_n, ({1'b0, sum_high_q} < ADLER_MOD), "sum_high not reduced")
	`FLA_ASSERT(a_clear, clk, arst_n, req.finish |=> (byte_count_q == 16'd0 && sum_low_q == 16'd1 && sum_high_q == 16'd0 && !drop_seen_q), "state not cleared after finish")

endmodule

// ===== bench/frame_length_adler32_header_tb.sv =====
// ---------------------------------------------------------------------------
// frame_length_adler32_header_tb
// Self-checking bench for the message framer. A scoreboard class tracks the
// running Adler-32, byte count and drop flag of the open message from every
// accepted request. On each finish it queues the header the block must emit,
// and it compares every header taken from the master stream field by field.
// Stimulus runs a directed part first, then a back-pressure phase and
// random messages under changing configuration.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module frame_length_adler32_header_tb;

	import fla32_pkg::*;

	// Clock period, reset length and run limits
	localparam int CLK_HALF      = 10;
	localparam int RESET_CYCLES  = 12;
	localparam int SETTLE_CYCLES = 4;        // settle time after every due header is out
	localparam int HOLD_CYCLES   = 400;      // long receiver hold-off
	localparam int RANDOM_ITEMS  = 1850;
	localparam int CYCLE_LIMIT   = 1000000;

	// One header as it leaves the block
	typedef struct packed {
		logic [15:0] length_field;
		logic [31:0] checksum;
		logic        present;
		logic        dropped;
	} header_t;

	// -----------------------------------------------------------------------
	// Scoreboard: running message state, register copy, queue of headers due
	// -----------------------------------------------------------------------
	class frame_header_scoreboard;
		int unsigned adler_a;
		int unsigned adler_b;
		int unsigned body_count;
		bit          drop_seen;
		bit          writes_allowed;
		bit          checksum_enable;
		header_t     pending_headers[$];
		int          errors;

		function new();
			writes_allowed  = 1'b1;
			checksum_enable = 1'b1;
			errors          = 0;
			clear_message();
		endfunction

		function void clear_message();
			adler_a    = 1;
			adler_b    = 0;
			body_count = 0;
			drop_seen  = 1'b0;
		endfunction

		// Buffer keeps head room and tail slack free besides the body
		function bit room_for(int unsigned n);
			return writes_allowed &&
				(HEAD_ROOM + body_count + n) < (BUFFER_BYTES - TAIL_SLACK);
		endfunction

		function void set_reg(fla_reg_t idx, logic value);
			case (idx)
				REG_WRITES_ALLOWED:  writes_allowed  = value;
				REG_CHECKSUM_ENABLE: checksum_enable = value;
				default: ;
			endcase
		endfunction

		// Fold one accepted request into the message; a finish queues a header
		function void note_request(fla_op_t op, logic [7:0] data);
			header_t hdr;
			if (op == OP_BODY) begin
				if (room_for(1)) begin
					adler_a    = (adler_a + data) % ADLER_MOD;
					adler_b    = (adler_b + adler_a) % ADLER_MOD;
					body_count = (body_count + 1) & 16'hFFFF;
				end else begin
					drop_seen = 1'b1;
				end
			end else begin
				hdr.present      = checksum_enable && room_for(TRAILER_LEN);
				hdr.length_field = 16'(body_count + (hdr.present ? TRAILER_LEN : 0));
				hdr.checksum     = hdr.present ? {adler_b[15:0], adler_a[15:0]} : 32'd0;
				hdr.dropped      = drop_seen;
				pending_headers.push_back(hdr);
				clear_message();
			end
		endfunction

		task report_mismatch(string field, logic [47:0] got, logic [47:0] want);
			errors++;
			$display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $time, field, got, want);
		endtask

		task check_header(logic [47:0] tdata, logic [1:0] tuser);
			header_t want;
			if (pending_headers.size() == 0) begin
				report_mismatch("header with none due", tdata, 48'd0);
				return;
			end
			want = pending_headers.pop_front();
			if (tdata[15:0] !== want.length_field)
				report_mismatch("length_field", tdata[15:0], want.length_field);
			if (tdata[47:16] !== want.checksum)
				report_mismatch("checksum", tdata[47:16], want.checksum);
			if (tuser[0] !== want.present)
				report_mismatch("checksum_present", tuser[0], want.present);
			if (tuser[1] !== want.dropped)
				report_mismatch("bytes_dropped", tuser[1], want.dropped);
		endtask
	endclass

	// -----------------------------------------------------------------------
	// Block connections; every input starts at a known value
	// -----------------------------------------------------------------------
	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_we        = 1'b0;
	logic        cfg_index     = 1'b0;
	logic        cfg_data      = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] data_byte
	logic        s_axis_tuser  = 1'b0;    // [0] op
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;            // [15:0] length_field, [47:16] checksum
	logic [1:0]  m_axis_tuser;            // [0] checksum_present, [1] bytes_dropped

	frame_length_adler32_header i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	frame_header_scoreboard board;
	bit          tx_gapless = 1'b0;   // sender offers back to back while set
	bit          hold_rx    = 1'b0;   // ask the receiver for a long hold-off
	int unsigned cycle_count = 0;

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Watchdog: end the run as failed once the cycle limit is reached
	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	// Idle length for either side: mostly none or short, now and then long
	function automatic int idle_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 82)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Bias bytes toward the extremes so both ends of the range show up often
	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	// -----------------------------------------------------------------------
	// Receiver: ready runs and stalls of random length, plus hold-offs
	// -----------------------------------------------------------------------
	initial begin
		int run_len;
		int stall_len;
		int i;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_rx) begin
				// hold off so the output register and the input stage both fill
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rx = 1'b0;
			end
			run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
				: $urandom_range(1, 12);
			m_axis_tready <= 1'b1;
			for (i = 0; i < run_len && !hold_rx; i++)
				@(posedge clk);
			stall_len = hold_rx ? 0 : idle_cycles();
			if (stall_len > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall_len) @(posedge clk);
			end
		end
	end

	// Take every header the master stream delivers; sampled before the edge updates
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_header(m_axis_tdata, m_axis_tuser);
	end

	// -----------------------------------------------------------------------
	// Sender tasks
	// -----------------------------------------------------------------------

	// Offer one request after an optional gap; hold it until the handshake
	task automatic send_request(fla_op_t op, logic [7:0] data);
		int gap;
		gap = tx_gapless ? 0 : idle_cycles();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= data;
		do
			@(posedge clk);
		while (!s_axis_tready);
		board.note_request(op, data);
	endtask

	task automatic send_body(logic [7:0] data);
		send_request(OP_BODY, data);
	endtask

	task automatic send_finish();
		// the byte lane is don't-care on a finish; keep it toggling
		send_request(OP_FINISH, pick_byte());
	endtask

	// Pause the sender until every due header is out, then let the pipe settle
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (board.pending_headers.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write, only with the block idle
	task automatic write_reg(fla_reg_t idx, logic value);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		board.set_reg(idx, value);
		cfg_we    <= 1'b0;
	endtask

	// -----------------------------------------------------------------------
	// Directed part: byte extremes, empty bodies, every register setting
	// -----------------------------------------------------------------------
	task automatic directed_checks();
		// empty body with the trailer on: checksum stays at its start value
		send_finish();
		send_body(8'h00);
		send_body(8'hFF);
		send_body(8'h80);
		send_body(8'h01);
		send_finish();
		// writes refused: every byte dropped, no trailer
		write_reg(REG_WRITES_ALLOWED, 1'b0);
		send_body(8'h55);
		send_body(8'hAA);
		send_finish();
		// trailer off: length is the bare body count
		write_reg(REG_WRITES_ALLOWED, 1'b1);
		write_reg(REG_CHECKSUM_ENABLE, 1'b0);
		send_body(8'hFF);
		send_body(8'h00);
		send_finish();
		// both off, empty body
		write_reg(REG_WRITES_ALLOWED, 1'b0);
		send_finish();
		// drop in the middle of a message that still gets its trailer
		write_reg(REG_WRITES_ALLOWED, 1'b1);
		write_reg(REG_CHECKSUM_ENABLE, 1'b1);
		send_body(8'h7F);
		write_reg(REG_WRITES_ALLOWED, 1'b0);
		send_body(8'hFE);
		write_reg(REG_WRITES_ALLOWED, 1'b1);
		send_body(8'h01);
		send_finish();
		// back-to-back finishes
		tx_gapless = 1'b1;
		send_finish();
		send_finish();
		tx_gapless = 1'b0;
	endtask

	// -----------------------------------------------------------------------
	// Back pressure: receiver holds off while short messages keep coming
	// -----------------------------------------------------------------------
	task automatic pressure_check();
		hold_rx    = 1'b1;
		tx_gapless = 1'b1;
		repeat (40) begin
			repeat ($urandom_range(0, 2)) send_body(pick_byte());
			send_finish();
		end
		tx_gapless = 1'b0;
		wait_drained();
	endtask

	// -----------------------------------------------------------------------
	// Random messages; configuration changes between and inside messages
	// -----------------------------------------------------------------------
	task automatic random_traffic();
		int sent;
		int since_cfg;
		int len;
		int r;
		sent      = 0;
		since_cfg = 0;
		while (sent < RANDOM_ITEMS) begin
			if (since_cfg >= 150) begin
				// new setting: writes mostly allowed, trailer either way
				write_reg(REG_WRITES_ALLOWED, $urandom_range(0, 3) != 0);
				write_reg(REG_CHECKSUM_ENABLE, 1'($urandom_range(0, 1)));
				tx_gapless = ($urandom_range(0, 4) == 0);
				since_cfg  = 0;
			end
			r = $urandom_range(0, 99);
			if (r < 8)
				len = 0;
			else if (r < 12)
				len = $urandom_range(100, 300);
			else
				len = $urandom_range(1, 24);
			repeat (len) begin
				// now and then flip a register mid-message
				if ($urandom_range(0, 199) == 0)
					write_reg(fla_reg_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				send_body(pick_byte());
			end
			send_finish();
			sent      += len + 1;
			since_cfg += len + 1;
		end
		tx_gapless = 1'b0;
	endtask

	// -----------------------------------------------------------------------
	// Main sequence
	// -----------------------------------------------------------------------
	initial begin
		board = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_checks();
		pressure_check();
		random_traffic();
		// drain what is still due, then let the pipe settle
		wait_drained();
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.pending_headers.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
